[design/tkpc_pkg.sv]
// Shared types and constants for the touch key press classifier.
// No dependencies; imported by touch_key_press_classifier_core.
`default_nettype none

package tkpc_pkg;

    // Fixed field widths
    localparam int unsigned KEY_W    = 2;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned WEIGHT_W = 9;

    // Keys that own a threshold register
    localparam int unsigned THRESHOLD_REGS = 3;
    localparam int unsigned KEY_COUNT_DEF  = 3;

    // Filter weight full scale
    localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 9'd256;

    // Stream payload widths
    localparam int unsigned IN_DATA_W  = 48;  // raw_sample, now_ms
    localparam int unsigned OUT_DATA_W = 24;  // flags, baseline, zero fill

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY0_THR   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY1_THR   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY2_THR   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SPIKE      = 3'd6;

    // Reset values
    localparam logic [SAMPLE_W-1:0] THR_RESET        = 16'd40;
    localparam logic [SAMPLE_W-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [SAMPLE_W-1:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET     = 9'd4;
    localparam logic [SAMPLE_W-1:0] SPIKE_RESET      = 16'd20;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSING = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_LONG     = 2'd3
    } phase_t;

endpackage : tkpc_pkg

`default_nettype wire

[design/touch_key_press_classifier_core.sv]
// Touch key press classifier, top level.
// Depends on tkpc_pkg for widths, register indexes, reset values and phase type.
//
// Usage:
//   s_* stream: one touch sample per word. s_tuser carries the key index,
//   s_tdata the raw sample and the millisecond timestamp.
//   m_* stream: exactly one result word per input word, in order. m_tuser
//   carries the key index, m_tdata the event flags and tracked baseline.
//   cfg_*: register writes (index, data), always ready; the user must write
//   only while the block is idle, which the block itself does not enforce.
//   An accepted word passes the input register, then the result register.
//   Throughput: one word per cycle while the receiver does not stall;
//   the per-key state is read and written in the stage between the two
//   registers, so words for the same key may follow back to back.
//   When the receiver stalls, the result register holds and the input
//   register fills; s_tready drops only when both are full.
//   Reset: all keys idle, baselines and press start times zero, registers
//   at their defaults, both streams empty.
//   A key index at or beyond the live key count changes no state and returns
//   zero flags and a zero baseline.
`default_nettype none

module touch_key_press_classifier_core
    import tkpc_pkg::*;
#(
    parameter int unsigned KEY_COUNT = KEY_COUNT_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // slave stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,   // [15:0] raw_sample, [47:16] now_ms
    input  wire logic [KEY_W-1:0]       s_tuser,   // [1:0] key_index
    // master stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_DATA_W-1:0]       m_tdata,   // [0] short_press, [1] long_press,
                                                   // [2] held, [18:3] tracked_baseline,
                                                   // [23:19] zero
    output logic [KEY_W-1:0]            m_tuser,   // [1:0] key_id
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned LIVE_KEYS =
        (KEY_COUNT < THRESHOLD_REGS) ? KEY_COUNT : THRESHOLD_REGS;

    // ---------------- configuration registers ----------------
    logic [SAMPLE_W-1:0] thr_reg [THRESHOLD_REGS];
    logic [SAMPLE_W-1:0] debounce_reg;
    logic [SAMPLE_W-1:0] long_press_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [SAMPLE_W-1:0] spike_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < THRESHOLD_REGS; i++)
            begin
                thr_reg[i] <= THR_RESET;
            end
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
            weight_reg     <= WEIGHT_RESET;
            spike_reg      <= SPIKE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KEY0_THR:   thr_reg[0]     <= cfg_data;
                REG_KEY1_THR:   thr_reg[1]     <= cfg_data;
                REG_KEY2_THR:   thr_reg[2]     <= cfg_data;
                REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                REG_WEIGHT:     weight_reg     <= cfg_data[WEIGHT_W-1:0];
                REG_SPIKE:      spike_reg      <= cfg_data;
                default:        ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                in_valid_reg;
    logic [KEY_W-1:0]    in_key_reg;
    logic [SAMPLE_W-1:0] in_raw_reg;
    logic [TIME_W-1:0]   in_now_reg;

    logic out_free;
    logic advance;

    assign out_free = !m_tvalid || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_key_reg <= s_tuser;
            in_raw_reg <= s_tdata[SAMPLE_W-1:0];
            in_now_reg <= s_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W];
        end
    end

    // ---------------- per-key state ----------------
    phase_t              phase_reg    [LIVE_KEYS];
    logic [TIME_W-1:0]   start_reg    [LIVE_KEYS];
    logic [SAMPLE_W-1:0] baseline_reg [LIVE_KEYS];

    // select the addressed key
    logic                key_live;
    phase_t              cur_phase;
    logic [TIME_W-1:0]   cur_start;
    logic [SAMPLE_W-1:0] cur_base;
    logic [SAMPLE_W-1:0] cur_thr;

    always_comb
    begin
        key_live  = 1'b0;
        cur_phase = PH_IDLE;
        cur_start = '0;
        cur_base  = '0;
        cur_thr   = '0;
        for (int i = 0; i < LIVE_KEYS; i++)
        begin
            if (in_key_reg == KEY_W'(i))
            begin
                key_live  = 1'b1;
                cur_phase = phase_reg[i];
                cur_start = start_reg[i];
                cur_base  = baseline_reg[i];
                cur_thr   = thr_reg[i];
            end
        end
    end

    // baseline filter: only small rises are blended in
    logic [WEIGHT_W-1:0]   w_sat;
    logic [WEIGHT_W-1:0]   w_inv;
    logic [SAMPLE_W-1:0]   rise;
    logic                  follow;
    logic [SAMPLE_W+8:0]   acc;
    logic [SAMPLE_W-1:0]   base_next;

    always_comb
    begin
        w_sat  = (weight_reg > FULL_WEIGHT) ? FULL_WEIGHT : weight_reg;
        w_inv  = FULL_WEIGHT - w_sat;
        rise   = in_raw_reg - cur_base;
        follow = (in_raw_reg >= cur_base) && (rise <= spike_reg);
        acc    = (SAMPLE_W+9)'(cur_base) * (SAMPLE_W+9)'(w_inv)
               + (SAMPLE_W+9)'(in_raw_reg) * (SAMPLE_W+9)'(w_sat);
        base_next = follow ? acc[SAMPLE_W+7:8] : cur_base;
    end

    // phase machine
    logic              touched;
    logic [TIME_W-1:0] elapsed;
    phase_t            phase_next;
    logic              start_load;
    logic              short_ev;
    logic              long_ev;

    always_comb
    begin
        touched    = in_raw_reg < cur_thr;
        elapsed    = in_now_reg - cur_start;
        phase_next = cur_phase;
        start_load = 1'b0;
        short_ev   = 1'b0;
        long_ev    = 1'b0;
        case (cur_phase)
            PH_IDLE:
            begin
                if (touched)
                begin
                    phase_next = PH_PRESSING;
                    start_load = 1'b1;
                end
            end
            PH_PRESSING:
            begin
                if (!touched)
                    phase_next = PH_IDLE;
                else if (elapsed >= TIME_W'(debounce_reg))
                    phase_next = PH_PRESSED;
            end
            PH_PRESSED:
            begin
                if (!touched)
                begin
                    phase_next = PH_IDLE;
                    short_ev   = 1'b1;
                end
                else if (elapsed >= TIME_W'(long_press_reg))
                begin
                    phase_next = PH_LONG;
                    long_ev    = 1'b1;
                end
            end
            PH_LONG:
            begin
                if (!touched)
                    phase_next = PH_IDLE;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIVE_KEYS; i++)
            begin
                phase_reg[i]    <= PH_IDLE;
                start_reg[i]    <= '0;
                baseline_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            for (int i = 0; i < LIVE_KEYS; i++)
            begin
                if (in_key_reg == KEY_W'(i))
                begin
                    phase_reg[i]    <= phase_next;
                    baseline_reg[i] <= base_next;
                    if (start_load)
                        start_reg[i] <= in_now_reg;
                end
            end
        end
    end

    // ---------------- result register ----------------
    logic                m_valid_reg;
    logic [KEY_W-1:0]    out_key_reg;
    logic                out_short_reg;
    logic                out_long_reg;
    logic                out_held_reg;
    logic [SAMPLE_W-1:0] out_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_key_reg   <= in_key_reg;
            out_short_reg <= key_live && short_ev;
            out_long_reg  <= key_live && long_ev;
            out_held_reg  <= key_live &&
                             ((phase_next == PH_PRESSED) || (phase_next == PH_LONG));
            out_base_reg  <= key_live ? base_next : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_key_reg;
    assign m_tdata  = {5'b0, out_base_reg, out_held_reg, out_long_reg, out_short_reg};

endmodule : touch_key_press_classifier_core

`default_nettype wire

[test/press_event_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the touch key press classifier: follows register writes, predicts
// one result word per accepted sample and compares it with the output stream.
// Depends on tkpc_pkg for widths, register indexes, reset values and phases.

module press_event_checker
    import tkpc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,
    input  logic [KEY_W-1:0]       s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_DATA_W-1:0]  m_tdata,
    input  logic [KEY_W-1:0]       m_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending,
    output int                     checked_count,
    output int                     short_count,
    output int                     long_count
);

    typedef struct packed {
        logic [KEY_W-1:0]    key_id;
        logic                short_ev;
        logic                long_ev;
        logic                held;
        logic [SAMPLE_W-1:0] baseline;
    } press_word_t;

    // per-key tracking
    phase_t              phase_q       [KEY_COUNT_DEF];
    logic [TIME_W-1:0]   touch_start_q [KEY_COUNT_DEF];
    logic [SAMPLE_W-1:0] baseline_q    [KEY_COUNT_DEF];

    // register copies
    logic [SAMPLE_W-1:0] thr_q [THRESHOLD_REGS];
    logic [SAMPLE_W-1:0] debounce_q;
    logic [SAMPLE_W-1:0] long_q;
    logic [WEIGHT_W-1:0] weight_q;
    logic [SAMPLE_W-1:0] spike_q;

    press_word_t due_words [$];
    press_word_t seen;
    press_word_t want;
    press_word_t predicted;
    int          mismatches;
    int          checked;
    int          shorts;
    int          longs;

    function automatic logic [SAMPLE_W-1:0] track_baseline(input logic [SAMPLE_W-1:0] base,
                                                           input logic [SAMPLE_W-1:0] raw);
        logic [WEIGHT_W-1:0] w;
        logic [24:0]         mix;
        // only rises up to the spike limit are blended in
        if (raw < base)
            return base;
        if (raw - base > spike_q)
            return base;
        w = (weight_q > FULL_WEIGHT) ? FULL_WEIGHT : weight_q;
        mix = 25'(base) * 25'(FULL_WEIGHT - w) + 25'(raw) * 25'(w);
        return mix[23:8];
    endfunction

    function automatic press_word_t classify_sample(input logic [KEY_W-1:0]    key,
                                                    input logic [SAMPLE_W-1:0] raw,
                                                    input logic [TIME_W-1:0]   now);
        press_word_t       r;
        phase_t            ph;
        logic              touched;
        logic [TIME_W-1:0] elapsed;
        r = '0;
        r.key_id = key;
        // keys without tracking state leave everything alone
        if (key >= KEY_COUNT_DEF || key >= THRESHOLD_REGS)
            return r;
        baseline_q[key] = track_baseline(baseline_q[key], raw);
        touched = raw < thr_q[key];
        elapsed = now - touch_start_q[key];
        ph = phase_q[key];
        case (ph)
            PH_IDLE:
                if (touched)
                begin
                    ph = PH_PRESSING;
                    touch_start_q[key] = now;
                end
            PH_PRESSING:
                if (!touched)
                    ph = PH_IDLE;
                else if (elapsed >= TIME_W'(debounce_q))
                    ph = PH_PRESSED;
            PH_PRESSED:
                if (!touched)
                begin
                    r.short_ev = 1'b1;
                    ph = PH_IDLE;
                end
                else if (elapsed >= TIME_W'(long_q))
                begin
                    r.long_ev = 1'b1;
                    ph = PH_LONG;
                end
            default:
                if (!touched)
                    ph = PH_IDLE;
        endcase
        phase_q[key] = ph;
        r.held = (ph == PH_PRESSED) || (ph == PH_LONG);
        r.baseline = baseline_q[key];
        return r;
    endfunction

    task automatic log_failure(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KEY_COUNT_DEF; k++)
            begin
                phase_q[k] = PH_IDLE;
                touch_start_q[k] = '0;
                baseline_q[k] = '0;
            end
            for (int k = 0; k < THRESHOLD_REGS; k++)
                thr_q[k] = THR_RESET;
            debounce_q = DEBOUNCE_RESET;
            long_q = LONG_PRESS_RESET;
            weight_q = WEIGHT_RESET;
            spike_q = SPIKE_RESET;
            due_words.delete();
            mismatches = 0;
            checked = 0;
            shorts = 0;
            longs = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_KEY0_THR:   thr_q[0] = cfg_data;
                    REG_KEY1_THR:   thr_q[1] = cfg_data;
                    REG_KEY2_THR:   thr_q[2] = cfg_data;
                    REG_DEBOUNCE:   debounce_q = cfg_data;
                    REG_LONG_PRESS: long_q = cfg_data;
                    REG_WEIGHT:     weight_q = cfg_data[WEIGHT_W-1:0];
                    REG_SPIKE:      spike_q = cfg_data;
                    default:        ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                seen = {m_tuser, m_tdata[0], m_tdata[1], m_tdata[2], m_tdata[18:3]};
                if (due_words.size() == 0)
                    log_failure($sformatf("result word with none due: key %0d tdata %h",
                                          m_tuser, m_tdata));
                else
                begin
                    want = due_words.pop_front();
                    checked++;
                    if (seen !== want || m_tdata[OUT_DATA_W-1:19] !== '0)
                        log_failure($sformatf(
                            {"word %0d: want key %0d short %b long %b held %b base %0d, ",
                             "got key %0d short %b long %b held %b base %0d fill %h"},
                            checked, want.key_id, want.short_ev, want.long_ev, want.held,
                            want.baseline, seen.key_id, seen.short_ev, seen.long_ev,
                            seen.held, seen.baseline, m_tdata[OUT_DATA_W-1:19]));
                end
            end

            if (s_tvalid && s_tready)
            begin
                predicted = classify_sample(s_tuser, s_tdata[SAMPLE_W-1:0],
                                            s_tdata[IN_DATA_W-1:SAMPLE_W]);
                shorts += predicted.short_ev;
                longs += predicted.long_ev;
                due_words.push_back(predicted);
            end
        end
        fail_count <= mismatches;
        pending <= due_words.size();
        checked_count <= checked;
        short_count <= shorts;
        long_count <= longs;
    end

endmodule

[test/tb_touch_key_press_classifier_core.sv]
`timescale 1ns / 100ps
// Testbench top for touch_key_press_classifier_core: drives samples with random gaps,
// register writes and random back-pressure, and gives the verdict.
// Depends on tkpc_pkg, the core and press_event_checker.

module tb_touch_key_press_classifier_core;
    import tkpc_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 11;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int DRAIN_CYCLES    = 8;
    localparam int STALL_LIMIT     = 2000;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic [KEY_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [KEY_W-1:0]       m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int pending;
    int checked_count;
    int short_count;
    int long_count;
    int idle_cycles = 0;
    int samples_sent;
    int settings_applied;

    logic                quiet;
    logic [TIME_W-1:0]   time_ms;
    logic [SAMPLE_W-1:0] thr_now  [THRESHOLD_REGS];
    logic                touching [THRESHOLD_REGS];
    int                  seg_left [THRESHOLD_REGS];

    always #(CLK_PERIOD / 2) clk = ~clk;

    touch_key_press_classifier_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    press_event_checker press_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .short_count   (short_count),
        .long_count    (long_count)
    );

    task automatic send_sample(input logic [KEY_W-1:0]    key,
                               input logic [SAMPLE_W-1:0] raw,
                               input logic [TIME_W-1:0]   now);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= key;
        s_tdata <= {now, raw};
        do
            @(posedge clk);
        while (!s_tready);
        samples_sent++;
    endtask

    // hold the sender until every result word is back, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx <= REG_KEY2_THR)
            thr_now[idx] = value;
    endtask

    task automatic apply_setting(input logic [SAMPLE_W-1:0] thr0, thr1, thr2,
                                 input logic [SAMPLE_W-1:0] debounce, long_ms,
                                 input logic [SAMPLE_W-1:0] weight, spike);
        drain();
        write_reg(REG_KEY0_THR, thr0);
        write_reg(REG_KEY1_THR, thr1);
        write_reg(REG_KEY2_THR, thr2);
        write_reg(REG_DEBOUNCE, debounce);
        write_reg(REG_LONG_PRESS, long_ms);
        write_reg(REG_WEIGHT, weight);
        write_reg(REG_SPIKE, spike);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_level(input int lo, input int hi);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom_range(lo, hi));
        endcase
    endfunction

    // one step of a press/release pattern on a random key
    task automatic gesture_sample();
        int                  k;
        logic [SAMPLE_W-1:0] raw;
        k = $urandom_range(0, THRESHOLD_REGS - 1);
        if (seg_left[k] == 0)
        begin
            touching[k] = !touching[k];
            seg_left[k] = touching[k] ? $urandom_range(1, 40) : $urandom_range(1, 6);
        end
        seg_left[k]--;
        time_ms += $urandom_range(0, 25);
        if (touching[k])
            raw = (thr_now[k] == 0) ? 16'd0 : SAMPLE_W'($urandom_range(0, thr_now[k] - 1));
        else if (thr_now[k] > 16'hF000)
            raw = 16'hFFFF;
        else
            raw = thr_now[k] + SAMPLE_W'($urandom_range(0, 3000));
        send_sample(KEY_W'(k), raw, time_ms);
    endtask

    // receiver: random stall before each word, none in quiet stretches
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[touch_key_press_classifier_core] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [SAMPLE_W-1:0] weight;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        quiet = 1'b0;
        time_ms = '0;
        samples_sent = 0;
        settings_applied = 0;
        for (int k = 0; k < THRESHOLD_REGS; k++)
        begin
            thr_now[k] = THR_RESET;
            touching[k] = 1'b0;
            seg_left[k] = 0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, on reset settings: threshold 40, debounce 50, long press 1000
        send_sample(2'd3, 16'h0000, 32'h0000_0000);        // key without state
        send_sample(2'd0, 16'hFFFF, 32'h0000_0000);        // rise beyond spike limit
        send_sample(2'd0, 16'd10, 32'd0);                  // touch starts
        send_sample(2'd0, 16'd10, 32'd49);                 // just short of debounce
        send_sample(2'd0, 16'd10, 32'd50);                 // pressed
        send_sample(2'd0, 16'd10, 32'd999);
        send_sample(2'd0, 16'd10, 32'd1000);               // long press fires
        send_sample(2'd0, 16'd10, 32'd2000);
        send_sample(2'd0, 16'd40, 32'd2001);               // at threshold counts as released
        send_sample(2'd1, 16'd39, 32'hFFFF_FFF0);
        send_sample(2'd1, 16'd39, 32'h0000_0030);          // debounce across the time wrap
        send_sample(2'd1, 16'd50, 32'h0000_0031);          // short press on release
        send_sample(2'd1, 16'd39, 32'd100);
        send_sample(2'd1, 16'd60, 32'd101);                // bounce back to idle
        send_sample(2'd2, 16'd20, 32'd5);                  // rise equal to spike limit
        send_sample(2'd2, 16'd21, 32'd6);                  // rise one over spike limit
        send_sample(2'd3, 16'hFFFF, 32'hFFFF_FFFF);
        send_sample(2'd2, 16'hFFFF, 32'hFFFF_FFFF);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                apply_setting(16'h0000, 16'hFFFF, 16'd1500, 16'd0, 16'd0, 16'd256, 16'd0);
            else if (p == 1)
                apply_setting(16'd2000, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'h01FF, 16'hFFFF);
            else
            begin
                case ($urandom_range(0, 4))
                    0:       weight = 16'd0;
                    1:       weight = 16'd256;
                    2:       weight = 16'($urandom_range(257, 511));
                    3:       weight = 16'($urandom);     // bits above the weight ignored
                    default: weight = 16'($urandom_range(1, 64));
                endcase
                apply_setting(pick_level(200, 4000), pick_level(200, 4000),
                              pick_level(200, 4000), pick_level(1, 120),
                              pick_level(100, 700), weight, pick_level(10, 3000));
            end
            quiet = (p % 4 == 3);
            case ($urandom_range(0, 2))
                0:       time_ms = '0;
                1:       time_ms = $urandom;
                default: time_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_sample(KEY_W'($urandom_range(0, 3)), SAMPLE_W'($urandom),
                                $urandom_range(0, 1) ? 32'($urandom) : time_ms);
                else
                    gesture_sample();
                if ($urandom_range(0, 99) == 0)
                    drain();
            end
        end
        quiet = 1'b0;
        drain();

        $display("Sent %0d samples across %0d register settings, keys 0 to 3, wrapping time.",
                 samples_sent, settings_applied + 1);
        $display("Checked %0d result words with %0d short and %0d long presses among them.",
                 checked_count, short_count, long_count);
        if (fail_count == 0 && pending == 0)
            $display("[touch_key_press_classifier_core] OK");
        else
            $display("[touch_key_press_classifier_core] ERROR");
        $finish;
    end

endmodule
